### hw/rtl/stree_pkg.sv
// ----------------------------------------------------------------------------
// stree_pkg
// Shared widths, codes and controller/datapath interface types for the
// segment tree range-sum block.
// ----------------------------------------------------------------------------
package stree_pkg;

  localparam int unsigned IDX_W          = 10;
  localparam int unsigned VAL_W          = 32;
  localparam int unsigned SUM_W          = 64;
  localparam int unsigned DEFAULT_LEAVES = 1024;

  typedef enum logic {
    ACT_UPDATE = 1'b0,
    ACT_QUERY  = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD,
    OP_CLEAR,
    OP_LEAF,
    OP_CLIMB,
    OP_WALK
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic leaf_skip;
    logic climb_last;
    logic walk_done;
  } dp_status_t;

endpackage

### hw/rtl/stree_ram.sv
// ----------------------------------------------------------------------------
// stree_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module stree_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 2048,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_a_i,
  input  logic [AddrW-1:0] raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

### hw/rtl/stree_ctrl.sv
// ----------------------------------------------------------------------------
// stree_ctrl
// Controller: clearing pass, leaf update with ancestor climb, range walk.
// ----------------------------------------------------------------------------
module stree_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  input  logic                   action_i,
  output logic                   busy,
  output logic                   result_valid_o,
  output stree_pkg::dp_cmd_t     cmd_o,
  input  stree_pkg::dp_status_t  status_i
);

  import stree_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LEAF,
    ST_CLIMB,
    ST_WALK
  } state_e;

  state_e state_q, state_d;
  logic   valid_q, valid_d;

  always_comb begin
    state_d   = state_q;
    valid_d   = 1'b0;
    cmd_o.op  = OP_HOLD;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.op = OP_CLEAR;
        if (status_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd_o.op = OP_LOAD;
          state_d  = (action_i == ACT_QUERY) ? ST_WALK : ST_LEAF;
        end
      end
      ST_LEAF: begin
        if (status_i.leaf_skip) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.op = OP_LEAF;
          state_d  = ST_CLIMB;
        end
      end
      ST_CLIMB: begin
        cmd_o.op = OP_CLIMB;
        if (status_i.climb_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_WALK: begin
        cmd_o.op = OP_WALK;
        if (status_i.walk_done) begin
          valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = valid_q;

`ifndef SYNTHESIS
  a_strobe_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |=> !valid_q)
    else $error("result strobe held longer than one cycle");

  a_strobe_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (state_q == ST_IDLE))
    else $error("result strobe while controller busy");

  a_update_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (action_i == ACT_UPDATE)) |=> !valid_q ##1 !valid_q)
    else $error("update produced a result beat");
`endif

endmodule

### hw/rtl/stree_datapath.sv
// ----------------------------------------------------------------------------
// stree_datapath
// Tree store, walk pointers, leaf/ancestor adder and query accumulator.
// ----------------------------------------------------------------------------
module stree_datapath #(
  parameter int unsigned LEAVES = stree_pkg::DEFAULT_LEAVES
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  stree_pkg::dp_cmd_t                 cmd_i,
  output stree_pkg::dp_status_t              status_o,
  input  logic [stree_pkg::IDX_W-1:0]        left_index_i,
  input  logic [stree_pkg::IDX_W-1:0]        right_index_i,
  input  logic signed [stree_pkg::VAL_W-1:0] value_i,
  output logic signed [stree_pkg::SUM_W-1:0] range_sum_o,
  output logic                               range_invalid_o
);

  import stree_pkg::*;

  localparam int unsigned NodeDepth = 2 * LEAVES;
  localparam int unsigned AW = $clog2(NodeDepth);
  localparam int unsigned PW = ((AW > IDX_W) ? AW : IDX_W) + 1;

  logic [PW-1:0]    pos_a_q, pos_a_d;
  logic [PW-1:0]    pos_b_q, pos_b_d;
  logic [SUM_W-1:0] node_q, node_d;
  logic [SUM_W-1:0] acc_q, acc_d;
  logic             take_a_q, take_a_d;
  logic             take_b_q, take_b_d;
  logic             invalid_q, invalid_d;
  logic             skip_q, skip_d;

  logic             we;
  logic [AW-1:0]    waddr;
  logic [SUM_W-1:0] wdata;
  logic [AW-1:0]    raddr_a;
  logic [AW-1:0]    raddr_b;
  logic [SUM_W-1:0] rdata_a;
  logic [SUM_W-1:0] rdata_b;

  logic             a_below_b;
  logic [PW-1:0]    parent;
  logic [SUM_W-1:0] climb_sum;

  assign a_below_b = (pos_a_q < pos_b_q);
  assign parent    = pos_a_q >> 1;
  assign climb_sum = node_q + rdata_a;

  always_comb begin
    logic [PW-1:0] left_ext;
    logic [PW-1:0] right_ext;
    logic [PW-1:0] hi;
    left_ext  = PW'(left_index_i);
    right_ext = PW'(right_index_i);
    hi        = (right_ext > PW'(LEAVES - 1)) ? PW'(LEAVES - 1) : right_ext;

    pos_a_d   = pos_a_q;
    pos_b_d   = pos_b_q;
    node_d    = node_q;
    acc_d     = acc_q;
    take_a_d  = take_a_q;
    take_b_d  = take_b_q;
    invalid_d = invalid_q;
    skip_d    = skip_q;
    we        = 1'b0;
    waddr     = pos_a_q[AW-1:0];
    wdata     = '0;
    raddr_a   = pos_a_q[AW-1:0];
    raddr_b   = pos_b_q[AW-1:0];

    case (cmd_i.op)
      OP_LOAD: begin
        pos_a_d   = left_ext + PW'(LEAVES);
        pos_b_d   = hi + PW'(LEAVES) + PW'(1);
        node_d    = {{(SUM_W - VAL_W){value_i[VAL_W-1]}}, value_i};
        acc_d     = '0;
        take_a_d  = 1'b0;
        take_b_d  = 1'b0;
        invalid_d = (left_index_i > right_index_i);
        skip_d    = (left_ext >= PW'(LEAVES));
      end
      OP_CLEAR: begin
        we      = 1'b1;
        pos_a_d = pos_a_q + PW'(1);
      end
      OP_LEAF: begin
        we      = 1'b1;
        wdata   = node_q;
        raddr_a = (pos_a_q ^ PW'(1)) >= PW'(NodeDepth) ? pos_a_q[AW-1:0]
                                                       : (pos_a_q[AW-1:0] ^ AW'(1));
      end
      OP_CLIMB: begin
        we      = 1'b1;
        waddr   = parent[AW-1:0];
        wdata   = climb_sum;
        node_d  = climb_sum;
        pos_a_d = parent;
        raddr_a = parent[AW-1:0] ^ AW'(1);
      end
      OP_WALK: begin
        acc_d = acc_q + (take_a_q ? rdata_a : '0) + (take_b_q ? rdata_b : '0);
        if (a_below_b) begin
          raddr_a  = pos_a_q[AW-1:0];
          raddr_b  = pos_b_q[AW-1:0] - AW'(1);
          take_a_d = pos_a_q[0];
          take_b_d = pos_b_q[0];
          pos_a_d  = (pos_a_q + PW'(pos_a_q[0])) >> 1;
          pos_b_d  = (pos_b_q - PW'(pos_b_q[0])) >> 1;
        end else begin
          take_a_d = 1'b0;
          take_b_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_a_q   <= '0;
      pos_b_q   <= '0;
      take_a_q  <= 1'b0;
      take_b_q  <= 1'b0;
      invalid_q <= 1'b0;
      skip_q    <= 1'b0;
    end else begin
      pos_a_q   <= pos_a_d;
      pos_b_q   <= pos_b_d;
      take_a_q  <= take_a_d;
      take_b_q  <= take_b_d;
      invalid_q <= invalid_d;
      skip_q    <= skip_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q <= node_d;
    acc_q  <= acc_d;
  end

  stree_ram #(
    .WIDTH (SUM_W),
    .DEPTH (NodeDepth)
  ) u_tree_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  assign status_o.clear_last = (pos_a_q == PW'(NodeDepth - 1));
  assign status_o.leaf_skip  = skip_q;
  assign status_o.climb_last = (parent == PW'(1));
  assign status_o.walk_done  = !a_below_b;

  assign range_sum_o     = acc_q;
  assign range_invalid_o = invalid_q;

`ifndef SYNTHESIS
  a_leaf_in_tree : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_LEAF) |-> (pos_a_q >= PW'(LEAVES)) && (pos_a_q < PW'(NodeDepth)))
    else $error("leaf write outside leaf row");

  a_climb_above_root : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_CLIMB) |-> (pos_a_q > PW'(1)))
    else $error("ancestor climb past root");

  a_walk_in_tree : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cmd_i.op == OP_WALK) && a_below_b) |-> (pos_b_q <= PW'(NodeDepth)))
    else $error("range walk reads beyond tree store");
`endif

endmodule

### hw/rtl/segment_tree_range_sum.sv
// ----------------------------------------------------------------------------
// segment_tree_range_sum
// Bottom-up segment tree over LEAVES positions with 64-bit wrapping sums.
// ----------------------------------------------------------------------------
// After reset the block holds busy high while it clears the tree store, one
// node per cycle. An item is taken when start is high and busy is low. An
// update (action 0) keeps busy high and returns nothing; an update to a
// position at or above LEAVES is dropped. A query (action 1) presents
// range_sum_o and range_invalid_o with result_valid_o for exactly one cycle
// right after busy falls; the receiver cannot stall that beat, and a new
// item may start in that same cycle. The tree walk visits one level per
// cycle through the two-read, one-write tree RAM.
module segment_tree_range_sum #(
  parameter int unsigned LEAVES = stree_pkg::DEFAULT_LEAVES
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic                               action_i,
  input  logic [stree_pkg::IDX_W-1:0]        left_index_i,
  input  logic [stree_pkg::IDX_W-1:0]        right_index_i,
  input  logic signed [stree_pkg::VAL_W-1:0] value_i,
  output logic                               result_valid_o,
  output logic signed [stree_pkg::SUM_W-1:0] range_sum_o,
  output logic                               range_invalid_o
);

  import stree_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  stree_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .action_i       (action_i),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .cmd_o          (cmd),
    .status_i       (status)
  );

  stree_datapath #(
    .LEAVES (LEAVES)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .left_index_i    (left_index_i),
    .right_index_i   (right_index_i),
    .value_i         (value_i),
    .range_sum_o     (range_sum_o),
    .range_invalid_o (range_invalid_o)
  );

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for segment_tree_range_sum. A directed table covers an
// empty tree, the index and value extremes and inverted ranges. Random
// updates and queries follow. Every query result is checked field by field
// against the table's values if given, else a software copy of the sum tree.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stree_pkg::*;

  localparam int unsigned LEAVES     = DEFAULT_LEAVES;
  localparam int unsigned RAND_BEATS = 1100;
  localparam int unsigned QUIET_TAIL = 150;
  localparam int unsigned IDLE_LIMIT = 8000;
  localparam int unsigned DRAIN_WAIT = 16;

  typedef struct packed {
    action_e            act;
    logic [IDX_W-1:0]   lo;
    logic [IDX_W-1:0]   hi;
    logic [VAL_W-1:0]   val;
    logic               typed;
    logic [SUM_W-1:0]   sum;
    logic               inv;
  } beat_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             inv;
  } answer_t;

  localparam int unsigned PLAN_LEN = 21;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic                    action_i;
  logic [IDX_W-1:0]        left_index_i;
  logic [IDX_W-1:0]        right_index_i;
  logic signed [VAL_W-1:0] value_i;
  logic                    result_valid_o;
  logic signed [SUM_W-1:0] range_sum_o;
  logic                    range_invalid_o;

  logic             beat_typed;
  logic [SUM_W-1:0] beat_sum;
  logic             beat_inv;

  logic [SUM_W-1:0] node_sum [2*LEAVES];
  answer_t          sums_due [$];
  int unsigned      err_count;
  int unsigned      idle_cycles;

  beat_t plan [PLAN_LEN];

  segment_tree_range_sum #(
    .LEAVES(LEAVES)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .action_i       (action_i),
    .left_index_i   (left_index_i),
    .right_index_i  (right_index_i),
    .value_i        (value_i),
    .result_valid_o (result_valid_o),
    .range_sum_o    (range_sum_o),
    .range_invalid_o(range_invalid_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic void leaf_write(int unsigned pos, logic [VAL_W-1:0] v);
    int unsigned k;
    if (pos >= LEAVES) return;
    k = pos + LEAVES;
    node_sum[k] = {{(SUM_W-VAL_W){v[VAL_W-1]}}, v};
    while (k > 1) begin
      node_sum[k >> 1] = node_sum[k] + node_sum[k ^ 1];
      k = k >> 1;
    end
  endfunction

  function automatic answer_t span_sum(int unsigned lo, int unsigned hi);
    answer_t          a;
    logic [SUM_W-1:0] acc_lo;
    logic [SUM_W-1:0] acc_hi;
    int unsigned      p;
    int unsigned      q;
    a = '0;
    if (lo > hi) begin
      a.inv = 1'b1;
      return a;
    end
    if (hi > LEAVES - 1) hi = LEAVES - 1;
    if (lo > hi) return a;
    acc_lo = '0;
    acc_hi = '0;
    p = lo + LEAVES;
    q = hi + LEAVES + 1;
    while (p < q) begin
      if (p[0]) begin
        acc_lo = acc_lo + node_sum[p];
        p = p + 1;
      end
      if (q[0]) begin
        q = q - 1;
        acc_hi = node_sum[q] + acc_hi;
      end
      p = p >> 1;
      q = q >> 1;
    end
    a.sum = acc_lo + acc_hi;
    return a;
  endfunction

  always @(posedge clk_i) begin
    answer_t got;
    answer_t want;
    logic    took;
    took = rst_ni && start && (busy === 1'b0);
    if (result_valid_o === 1'b1) begin
      got.sum = range_sum_o;
      got.inv = range_invalid_o;
      if (sums_due.size() == 0) begin
        $display("%0t tb: unexpected result sum %h invalid %b", $time, got.sum, got.inv);
        err_count++;
      end else begin
        want = sums_due.pop_front();
        if (got.sum !== want.sum) begin
          $display("%0t tb: range_sum expected %h actual %h", $time, want.sum, got.sum);
          err_count++;
        end
        if (got.inv !== want.inv) begin
          $display("%0t tb: range_invalid expected %b actual %b", $time, want.inv, got.inv);
          err_count++;
        end
      end
    end
    if (took) begin
      if (action_e'(action_i) == ACT_UPDATE) begin
        leaf_write(32'(left_index_i), value_i);
      end else begin
        want = span_sum(32'(left_index_i), 32'(right_index_i));
        if (beat_typed) begin
          want.sum = beat_sum;
          want.inv = beat_inv;
        end
        sums_due.insert(sums_due.size(), want);
      end
    end
    if (took || result_valid_o === 1'b1) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  task automatic send_beat(beat_t b, int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start         <= 1'b1;
    action_i      <= b.act;
    left_index_i  <= b.lo;
    right_index_i <= b.hi;
    value_i       <= b.val;
    beat_typed    <= b.typed;
    beat_sum      <= b.sum;
    beat_inv      <= b.inv;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  task automatic drain_pause();
    start <= 1'b0;
    @(posedge clk_i);
    while (sums_due.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    beat_t       b;
    int unsigned gap;
    int unsigned span;
    int unsigned pick;
    logic [VAL_W-1:0] edge_vals [4];

    edge_vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000};
    plan = '{
      '{ACT_QUERY,  10'd0,    10'd1023, 32'h0,         1'b1, 64'h0, 1'b0},
      '{ACT_QUERY,  10'd1023, 10'd0,    32'hFFFF_FFFF, 1'b1, 64'h0, 1'b1},
      '{ACT_QUERY,  10'd1,    10'd0,    32'h0,         1'b1, 64'h0, 1'b1},
      '{ACT_QUERY,  10'd512,  10'd512,  32'h0,         1'b1, 64'h0, 1'b0},
      '{ACT_UPDATE, 10'd0,    10'd1023, 32'h7FFF_FFFF, 1'b0, 64'h0, 1'b0},
      '{ACT_UPDATE, 10'd1023, 10'd0,    32'h8000_0000, 1'b0, 64'h0, 1'b0},
      '{ACT_UPDATE, 10'd512,  10'd512,  32'hFFFF_FFFF, 1'b0, 64'h0, 1'b0},
      '{ACT_QUERY,  10'd0,    10'd0,    32'h0,         1'b1, 64'h0000_0000_7FFF_FFFF, 1'b0},
      '{ACT_QUERY,  10'd1023, 10'd1023, 32'h0,         1'b1, 64'hFFFF_FFFF_8000_0000, 1'b0},
      '{ACT_QUERY,  10'd512,  10'd512,  32'h0,         1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0},
      '{ACT_QUERY,  10'd0,    10'd1023, 32'h0,         1'b0, 64'h0, 1'b0},
      '{ACT_QUERY,  10'd1,    10'd1022, 32'h0,         1'b0, 64'h0, 1'b0},
      '{ACT_UPDATE, 10'd341,  10'd682,  32'h5555_5555, 1'b0, 64'h0, 1'b0},
      '{ACT_UPDATE, 10'd682,  10'd341,  32'hAAAA_AAAA, 1'b0, 64'h0, 1'b0},
      '{ACT_QUERY,  10'd341,  10'd682,  32'h0,         1'b0, 64'h0, 1'b0},
      '{ACT_QUERY,  10'd0,    10'd1,    32'h0,         1'b0, 64'h0, 1'b0},
      '{ACT_QUERY,  10'd1022, 10'd1023, 32'h0,         1'b0, 64'h0, 1'b0},
      '{ACT_QUERY,  10'd511,  10'd512,  32'h0,         1'b0, 64'h0, 1'b0},
      '{ACT_UPDATE, 10'd0,    10'd0,    32'h0,         1'b0, 64'h0, 1'b0},
      '{ACT_QUERY,  10'd0,    10'd1023, 32'h0,         1'b0, 64'h0, 1'b0},
      '{ACT_QUERY,  10'd1023, 10'd1022, 32'hFFFF_FFFF, 1'b1, 64'h0, 1'b1}
    };

    foreach (node_sum[k]) node_sum[k] = '0;
    err_count     = 0;
    idle_cycles   = 0;
    rst_ni        = 1'b0;
    start         = 1'b0;
    action_i      = 1'b0;
    left_index_i  = '0;
    right_index_i = '0;
    value_i       = '0;
    beat_typed    = 1'b0;
    beat_sum      = '0;
    beat_inv      = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 7) : 0;
      send_beat(plan[i], gap);
    end
    drain_pause();

    for (int unsigned i = 0; i < RAND_BEATS; i++) begin
      b       = '0;
      b.act   = ($urandom_range(0, 1) == 0) ? ACT_UPDATE : ACT_QUERY;
      b.lo    = IDX_W'($urandom_range(0, LEAVES - 1));
      b.hi    = IDX_W'($urandom_range(0, LEAVES - 1));
      b.val   = $urandom;
      if ($urandom_range(0, 9) == 0) b.val = edge_vals[$urandom_range(0, 3)];
      if (b.act == ACT_QUERY) begin
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
          span = $urandom_range(0, 15);
          b.hi = IDX_W'((b.lo + span > LEAVES - 1) ? LEAVES - 1 : b.lo + span);
        end else if (pick < 9 && b.lo > b.hi) begin
          {b.lo, b.hi} = {b.hi, b.lo};
        end
      end
      gap = 0;
      if (i < RAND_BEATS - QUIET_TAIL && (i / 64) % 3 != 2 && $urandom_range(0, 3) == 0)
        gap = $urandom_range(1, 7);
      send_beat(b, gap);
      if (i % 250 == 249 && i < RAND_BEATS - QUIET_TAIL) drain_pause();
    end
    start <= 1'b0;

    while (sums_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
